// File: hdl/rmsacc_pkg.sv
// Package for the RMS accumulator: sizes, controller states and the
// command/status structs between controller and datapath. No dependencies.
package rmsacc_pkg;

  // Sample and count sizes
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned COUNT_BITS  = 24;
  localparam int unsigned SQ_BITS     = 2 * SAMPLE_BITS;

  // Sum of squares and result sizes
  localparam int unsigned SUM_BITS    = 56;
  localparam int unsigned FRAC_BITS   = 16;  // mean is scaled by 2^16
  localparam int unsigned Q_BITS      = 48;  // quotient width that still has a 24-bit root
  localparam int unsigned RMS_BITS    = 24;
  localparam int unsigned REM_BITS    = SUM_BITS + FRAC_BITS - Q_BITS;

  // Iteration counts of the shared divide and root loops
  localparam int unsigned DIV_STEPS   = Q_BITS;
  localparam int unsigned SQRT_STEPS  = Q_BITS / 2;
  localparam int unsigned STEP_BITS   = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    ST_ACC,
    ST_CHECK,
    ST_DIV,
    ST_SQRT,
    ST_FINISH
  } ctrl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;     // register the square of an input sample
    logic accumulate;  // add the registered square, count the sample
    logic start;       // close the run: load divider, clear accumulator
    logic latch_big;   // record the quotient range check
    logic div_step;    // one restoring divide step
    logic sqrt_step;   // one square root step
    logic load_out;    // load the result register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic too_big;     // quotient reaches 2^48, root saturates
  } dp_sts_t;

endpackage

// File: hdl/rms_accumulator_unit.sv
// Streaming RMS of unsigned samples, unsigned Q16.8 result.
// Top level: joins rmsacc_ctrl and rmsacc_dp; uses rmsacc_pkg.
//
// Input channel: in_valid_i / in_stall_o with sample_i and last_i. Ordinary
// samples are taken one per cycle; each is squared in the transfer cycle and
// added to a 56-bit saturating sum in the following cycle, with a saturating count.
// A sample with last_i set closes the run: the sum is scaled by 2^16, divided
// by the count one quotient bit per cycle and the square root is taken two
// radicand bits per cycle, both in one shared register
// set. The divide and root loops set the latency.
// Output channel: out_valid_o / out_stall_i with rms_o and overflow_o, one
// result per run. The result is loaded in ST_FINISH after ST_CHECK, ST_DIV and
// ST_SQRT (the two loops are skipped when the quotient saturates); in_stall_o
// stays high from the transfer of the last sample until the result is loaded.
// A run that ends while the previous result is still stalled waits in place;
// other samples keep flowing while a result waits for its transfer.
// overflow_o flags a run in which the count or the sum saturated; rms_o
// saturates at all ones if the root does not fit in 24 bits.
// Reset (rst_ni low, asynchronous) clears the sum, count, flag and both
// valid signals.
module rms_accumulator_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [rmsacc_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic                               last_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [rmsacc_pkg::RMS_BITS-1:0]    rms_o,
  output logic                               overflow_o
);
  import rmsacc_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  rmsacc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  rmsacc_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sample_i   (sample_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .rms_o      (rms_o),
    .overflow_o (overflow_o)
  );

endmodule

// File: hdl/rmsacc_dp.sv
// Datapath of the RMS accumulator: squarer, saturating accumulator, bit-serial
// divider, bit-serial square root and result register. Uses rmsacc_pkg.
module rmsacc_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [rmsacc_pkg::SAMPLE_BITS-1:0] sample_i,
  input  rmsacc_pkg::ctrl_cmd_t            cmd_i,
  output rmsacc_pkg::dp_sts_t              sts_o,
  output logic [rmsacc_pkg::RMS_BITS-1:0]  rms_o,
  output logic                             overflow_o
);
  import rmsacc_pkg::*;

  logic [SQ_BITS-1:0]    sq_q;
  logic [SUM_BITS-1:0]   sum_q, sum_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic                  sat_q, sat_d;
  logic [SUM_BITS:0]     sum_add;

  logic [REM_BITS-1:0]   rem_q;
  logic [REM_BITS-1:0]   dvs_q;
  logic [Q_BITS-1:0]     num_q;
  logic [Q_BITS-1:0]     root_q;
  logic [Q_BITS-1:0]     bit_q;
  logic                  ovf_q;
  logic                  big_q;
  logic [RMS_BITS-1:0]   rms_q;
  logic                  ovf_out_q;

  logic [REM_BITS:0]     div_t;
  logic                  div_ge;
  logic [REM_BITS:0]     div_diff;
  logic [Q_BITS-1:0]     sqrt_t;
  logic                  sqrt_ge;

  // Squarer, one multiply per transfer
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      sq_q <= sample_i * sample_i;
    end
  end

  // Saturating sum and count for the current run
  always_comb begin
    sum_add = {1'b0, sum_q} + (SUM_BITS + 1)'(sq_q);
    sum_d   = sum_q;
    cnt_d   = cnt_q;
    sat_d   = sat_q;
    if (sum_add[SUM_BITS]) begin
      sum_d = '1;
      sat_d = 1'b1;
    end else begin
      sum_d = sum_add[SUM_BITS-1:0];
    end
    if (cnt_q == '1) begin
      sat_d = 1'b1;
    end else begin
      cnt_d = cnt_q + COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
      sat_q <= 1'b0;
    end else if (cmd_i.accumulate) begin
      if (cmd_i.start) begin
        sum_q <= '0;
        cnt_q <= '0;
        sat_q <= 1'b0;
      end else begin
        sum_q <= sum_d;
        cnt_q <= cnt_d;
        sat_q <= sat_d;
      end
    end
  end

  // Divide step: shift one numerator bit into the partial remainder
  always_comb begin
    div_t    = {rem_q, num_q[Q_BITS-1]};
    div_ge   = div_t >= {1'b0, dvs_q};
    div_diff = div_t - {1'b0, dvs_q};
  end

  // Root step, same recurrence as the bit-pair method
  always_comb begin
    sqrt_t  = root_q + bit_q;
    sqrt_ge = num_q >= sqrt_t;
  end

  // The numerator register becomes the quotient, then the root radicand
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      rem_q  <= sum_d[SUM_BITS-1 -: REM_BITS];
      num_q  <= {sum_d[SUM_BITS-REM_BITS-1:0], {FRAC_BITS{1'b0}}};
      dvs_q  <= REM_BITS'(cnt_d);
      ovf_q  <= sat_d;
      root_q <= '0;
      bit_q  <= Q_BITS'(1) << (Q_BITS - 2);
    end else if (cmd_i.div_step) begin
      rem_q <= div_ge ? div_diff[REM_BITS-1:0] : div_t[REM_BITS-1:0];
      num_q <= {num_q[Q_BITS-2:0], div_ge};
    end else if (cmd_i.sqrt_step) begin
      if (sqrt_ge) begin
        num_q  <= num_q - sqrt_t;
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  // Range check: quotient >= 2^48 exactly when the top sum bits reach the count
  assign sts_o.too_big = rem_q >= dvs_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_big) begin
      big_q <= sts_o.too_big;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      rms_q     <= big_q ? '1 : root_q[RMS_BITS-1:0];
      ovf_out_q <= ovf_q;
    end
  end

  assign rms_o      = rms_q;
  assign overflow_o = ovf_out_q;

endmodule

// File: hdl/rmsacc_ctrl.sv
// Controller of the RMS accumulator: handshakes, sample pipeline flag and the
// sequence of divide and root steps. Uses rmsacc_pkg.
module rmsacc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  last_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output rmsacc_pkg::ctrl_cmd_t cmd_o,
  input  rmsacc_pkg::dp_sts_t   sts_i
);
  import rmsacc_pkg::*;

  ctrl_state_e          state_q, state_d;
  logic [STEP_BITS-1:0] step_q, step_d;
  logic                 pipe_vld_q, pipe_vld_d;
  logic                 pipe_last_q, pipe_last_d;
  logic                 out_vld_q, out_vld_d;
  logic                 in_xfer;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACC;
      step_q      <= '0;
      pipe_vld_q  <= 1'b0;
      pipe_last_q <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      pipe_vld_q  <= pipe_vld_d;
      pipe_last_q <= pipe_last_d;
      out_vld_q   <= out_vld_d;
    end
  end

  // Hold input off while a run is being closed
  assign in_stall_o  = (state_q != ST_ACC) || (pipe_vld_q && pipe_last_q);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_vld_q;

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    cmd_o       = '0;
    pipe_vld_d  = in_xfer;
    pipe_last_d = in_xfer ? last_i : pipe_last_q;
    out_vld_d   = (out_vld_q && !out_stall_i) ? 1'b0 : out_vld_q;

    cmd_o.capture = in_xfer;

    case (state_q)
      ST_ACC: begin
        if (pipe_vld_q) begin
          cmd_o.accumulate = 1'b1;
          if (pipe_last_q) begin
            cmd_o.start = 1'b1;
            state_d     = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        cmd_o.latch_big = 1'b1;
        step_d          = '0;
        state_d         = sts_i.too_big ? ST_FINISH : ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (step_q == STEP_BITS'(DIV_STEPS - 1)) begin
          step_d  = '0;
          state_d = ST_SQRT;
        end else begin
          step_d = step_q + STEP_BITS'(1);
        end
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (step_q == STEP_BITS'(SQRT_STEPS - 1)) begin
          step_d  = '0;
          state_d = ST_FINISH;
        end else begin
          step_d = step_q + STEP_BITS'(1);
        end
      end
      ST_FINISH: begin
        // wait until the result register is free
        if (!(out_vld_q && out_stall_i)) begin
          cmd_o.load_out = 1'b1;
          out_vld_d      = 1'b1;
          state_d        = ST_ACC;
        end
      end
      default: begin
        state_d = ST_ACC;
      end
    endcase
  end

endmodule

// File: tb/sv/rms_accumulator_checker.sv
`timescale 1ns / 1ps
// Scoreboard for rms_accumulator_unit: watches both channels, predicts each
// run's RMS result and compares it with what the block hands out. Uses rmsacc_pkg.
module rms_accumulator_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_stall_i,
  input  logic [rmsacc_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic                               last_i,
  input  logic                               out_valid_i,
  input  logic                               out_stall_i,
  input  logic [rmsacc_pkg::RMS_BITS-1:0]    rms_i,
  input  logic                               overflow_i,
  output int                                 fail_count_o,
  output int                                 pending_o
);
  import rmsacc_pkg::*;

  typedef struct packed {
    logic [RMS_BITS-1:0] rms;
    logic                overflow;
  } rms_result_t;

  // Run state: sum of squares, sample count, saturation seen
  logic [SUM_BITS-1:0]   run_sum_sq;
  logic [COUNT_BITS-1:0] run_count;
  logic                  run_sat;
  rms_result_t           rms_expect_q[$];

  // floor(sqrt(q)), one result bit per pass from the top down
  function automatic logic [RMS_BITS-1:0] floor_root(input logic [79:0] q);
    logic [79:0] root;
    logic [79:0] trial;
    root = '0;
    for (int b = RMS_BITS - 1; b >= 0; b--) begin
      trial = root | (80'd1 << b);
      if (trial * trial <= q) root = trial;
    end
    return root[RMS_BITS-1:0];
  endfunction

  // Fold one sample into the run; on last, close the run and queue its result
  task automatic predict_rms(input logic [SAMPLE_BITS-1:0] s, input logic is_last);
    logic [79:0] sq;
    logic [79:0] sum_next;
    logic [79:0] scaled;
    logic [79:0] q;
    rms_result_t res;
    sq = 80'(s) * 80'(s);
    sum_next = 80'(run_sum_sq) + sq;
    if (sum_next > 80'({SUM_BITS{1'b1}})) begin
      run_sum_sq = '1;
      run_sat = 1'b1;
    end else begin
      run_sum_sq = sum_next[SUM_BITS-1:0];
    end
    if (run_count == '1) begin
      run_sat = 1'b1;
    end else begin
      run_count = run_count + 1'b1;
    end
    if (is_last) begin
      scaled = 80'(run_sum_sq) << FRAC_BITS;
      q = scaled / 80'(run_count);
      if (q >= (80'd1 << Q_BITS)) res.rms = '1;
      else res.rms = floor_root(q);
      res.overflow = run_sat;
      rms_expect_q.push_back(res);
      run_sum_sq = '0;
      run_count = '0;
      run_sat = 1'b0;
    end
  endtask

  // Watch both channels at every rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    rms_result_t exp_res;
    if (!rst_ni) begin
      run_sum_sq = '0;
      run_count = '0;
      run_sat = 1'b0;
      rms_expect_q.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (rms_expect_q.size() == 0) begin
          $display("%0t: result with none expected: rms %0d overflow %0d",
                   $time, rms_i, overflow_i);
          fail_count_o++;
        end else begin
          exp_res = rms_expect_q.pop_front();
          if (rms_i !== exp_res.rms) begin
            $display("%0t: rms mismatch: expected %0d, actual %0d",
                     $time, exp_res.rms, rms_i);
            fail_count_o++;
          end
          if (overflow_i !== exp_res.overflow) begin
            $display("%0t: overflow mismatch: expected %0d, actual %0d",
                     $time, exp_res.overflow, overflow_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) predict_rms(sample_i, last_i);
      pending_o = rms_expect_q.size();
    end
  end

endmodule

// File: tb/sv/tb_rms_accumulator_unit.sv
`timescale 1ns / 1ps
// Testbench top for rms_accumulator_unit: clock, reset, sample stimulus and
// random output stall. Needs rmsacc_pkg and rms_accumulator_checker.
module tb_rms_accumulator_unit;
  import rmsacc_pkg::*;

  localparam int RANDOM_ITEMS = 1700;
  localparam int CYCLE_LIMIT  = 1000000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic [SAMPLE_BITS-1:0] sample_i = '0;
  logic                   last_i = 1'b0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [RMS_BITS-1:0]    rms_o;
  logic                   overflow_o;
  int                     fail_count;
  int                     pending_results;
  int                     cycle_count = 0;
  logic                   gaps_on = 1'b1;
  logic                   stalls_on = 1'b1;

  rms_accumulator_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sample_i   (sample_i),
    .last_i     (last_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .rms_o      (rms_o),
    .overflow_o (overflow_o)
  );

  rms_accumulator_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .sample_i    (sample_i),
    .last_i      (last_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .rms_i       (rms_o),
    .overflow_i  (overflow_o),
    .fail_count_o(fail_count),
    .pending_o   (pending_results)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Run time guard
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL rms_accumulator_unit");
      $finish;
    end
  end

  // Receiver: stall in random bursts while enabled
  initial begin
    forever begin
      @(negedge clk_i);
      if (stalls_on && $urandom_range(0, 5) == 0) begin
        out_stall_i = 1'b1;
        repeat ($urandom_range(1, 18)) @(negedge clk_i);
        out_stall_i = 1'b0;
      end
    end
  end

  // One sample transfer, with an optional gap ahead of it
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] s, input logic is_last);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    sample_i = s;
    last_i = is_last;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  function automatic logic [SAMPLE_BITS-1:0] pick_sample(input int mode);
    case (mode)
      0: return $urandom_range(0, 1) ? '1 : '0;
      1: return SAMPLE_BITS'($urandom_range(0, 15));
      2: return SAMPLE_BITS'($urandom_range(16'hff00, 16'hffff));
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  initial begin
    int sent;
    int run_len;
    int mode;

    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed runs: zero, full scale, unit, bit patterns, mixed, short runs
    send_sample('0, 1'b1);
    send_sample('1, 1'b1);
    send_sample(16'd1, 1'b1);
    send_sample(16'haaaa, 1'b0);
    send_sample(16'h5555, 1'b1);
    send_sample('1, 1'b0);
    send_sample('0, 1'b0);
    send_sample('1, 1'b0);
    send_sample('0, 1'b1);
    for (int i = 0; i < 6; i++) send_sample('1, i == 5);
    send_sample(16'd2, 1'b0);
    send_sample(16'd3, 1'b0);
    send_sample(16'd5, 1'b1);
    send_sample(16'h8000, 1'b1);
    send_sample(16'h7fff, 1'b1);

    // Random runs; idle-free stretch in the middle and at the end
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      gaps_on = (sent < 600) || (sent >= 900 && sent < 1400);
      stalls_on = gaps_on;
      case ($urandom_range(0, 19))
        0:                  run_len = $urandom_range(41, 300);
        1, 2, 3, 4, 5:      run_len = $urandom_range(9, 40);
        default:            run_len = $urandom_range(1, 8);
      endcase
      mode = $urandom_range(0, 5);
      for (int i = 0; i < run_len; i++) begin
        send_sample(pick_sample(mode), i == run_len - 1);
      end
      sent += run_len;
    end
    in_valid_i = 1'b0;
    last_i = 1'b0;
    stalls_on = 1'b0;

    // Drain, then allow the block's latency to expose any stray result
    while (pending_results != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);

    if (fail_count == 0) begin
      $display("PASS rms_accumulator_unit");
    end else begin
      $display("FAIL rms_accumulator_unit");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/rmsacc_pkg.sv
hdl/rmsacc_dp.sv
hdl/rmsacc_ctrl.sv
hdl/rms_accumulator_unit.sv
tb/sv/rms_accumulator_checker.sv
tb/sv/tb_rms_accumulator_unit.sv
